// ===== design/sensor_calibration_compensation_macros.svh =====
// Assertion macros for the sensor calibration compensation block.
// Included by files that carry concurrent checks; empty when SYNTH is set.
`ifndef SENSOR_CALIBRATION_COMPENSATION_MACROS_SVH
`define SENSOR_CALIBRATION_COMPENSATION_MACROS_SVH
`ifndef SYNTH
`define SCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc check failed");
`define SCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc check failed");
`else
`define SCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SCC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/scc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the compensation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

  typedef enum logic [2:0] {
    CFG_TEMP_CAL   = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_LAST = 3'd3,
    CFG_HUM_CAL    = 3'd4,
    CFG_FINE_OFF   = 3'd5
  } cfg_idx_t;

  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int HUM_MAX   = 419430400;
  localparam int PRESS_MAX = 33554431;
  localparam int DIV_BITS  = 64;

  typedef struct packed {
    logic [47:0] t_cal;
    logic [63:0] p_lo;
    logic [63:0] p_hi;
    logic [15:0] p_last;
    logic [63:0] h_cal;
    logic [19:0] t_off;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [14:0] tc;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic [63:0] un;
    logic [63:0] ud;
    side_t       sd;
  } fd_t;

  typedef struct packed {
    logic [63:0] q;
    side_t       sd;
  } db_t;

  typedef struct packed {
    logic [14:0] tc;
    logic [24:0] press;
    logic        pvld;
    logic [16:0] hum;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } skid_stat_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // low 64 bits of a times signed 16-bit b
  function automatic logic [63:0] mul64s16(input logic [63:0] a, input logic [15:0] b);
    logic [79:0] p;
    p = {16'b0, a} * {64'b0, b};
    return p[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'b0);
  endfunction

endpackage
`default_nettype wire

// ===== design/scc_front.sv =====
// Front pipeline: fine temperature, temperature, humidity and the pressure
// dividend and divisor. Twelve stages. Uses scc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scc_front import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_vld,
  input  wire logic [19:0] raw_t,
  input  wire logic [19:0] raw_p,
  input  wire logic [15:0] raw_h,
  input  wire cfg_t        cfg,
  output logic             out_vld,
  output fd_t              out
);

  logic [11:0] vld;

  logic [15:0] t1;
  logic [31:0] t2s, t3s, offs;
  logic [15:0] p1, p2, p3, p4, p5, p6;
  logic [63:0] p4x;
  logic [31:0] h1u, h2s, h3u, h4s, h5s, h6s;

  assign t1   = cfg.t_cal[15:0];
  assign t2s  = {{16{cfg.t_cal[31]}}, cfg.t_cal[31:16]};
  assign t3s  = {{16{cfg.t_cal[47]}}, cfg.t_cal[47:32]};
  assign offs = {{12{cfg.t_off[19]}}, cfg.t_off};
  assign p1   = cfg.p_lo[15:0];
  assign p2   = cfg.p_lo[31:16];
  assign p3   = cfg.p_lo[47:32];
  assign p4   = cfg.p_lo[63:48];
  assign p5   = cfg.p_hi[15:0];
  assign p6   = cfg.p_hi[31:16];
  assign p4x  = sx16(p4);
  assign h1u  = {24'b0, cfg.h_cal[7:0]};
  assign h2s  = {{16{cfg.h_cal[23]}}, cfg.h_cal[23:8]};
  assign h3u  = {24'b0, cfg.h_cal[31:24]};
  assign h4s  = {{20{cfg.h_cal[43]}}, cfg.h_cal[43:32]};
  assign h5s  = {{20{cfg.h_cal[55]}}, cfg.h_cal[55:44]};
  assign h6s  = {{24{cfg.h_cal[63]}}, cfg.h_cal[63:56]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[10:0], in_vld};
    end
  end

  // stage 1
  logic [31:0] a1, b1;
  logic [31:0] f1_ma, f1_mb;
  logic [19:0] f1_p;
  logic [15:0] f1_h;
  assign a1 = {15'b0, raw_t[19:3]} - {15'b0, t1, 1'b0};
  assign b1 = {16'b0, raw_t[19:4]} - {16'b0, t1};
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ma <= a1 * t2s;
      f1_mb <= b1 * b1;
      f1_p  <= raw_p;
      f1_h  <= raw_h;
    end
  end

  // stage 2
  logic [31:0] f2_v1, f2_mc;
  logic [19:0] f2_p;
  logic [15:0] f2_h;
  always_ff @(posedge clk) begin
    if (adv) begin
      f2_v1 <= sra32(f1_ma, 11);
      f2_mc <= sra32(f1_mb, 12) * t3s;
      f2_p  <= f1_p;
      f2_h  <= f1_h;
    end
  end

  // stage 3: fine temperature
  logic [31:0] f3_tf;
  logic [19:0] f3_p;
  logic [15:0] f3_h;
  always_ff @(posedge clk) begin
    if (adv) begin
      f3_tf <= f2_v1 + sra32(f2_mc, 14) + offs;
      f3_p  <= f2_p;
      f3_h  <= f2_h;
    end
  end

  // stage 4: temperature out, pressure and humidity offsets
  logic [31:0] t5;
  logic signed [31:0] tcs;
  logic [14:0] tc4;
  logic [33:0] f4_q1;
  logic [31:0] f4_x;
  logic [14:0] f4_tc;
  logic [19:0] f4_p;
  logic [15:0] f4_h;
  assign t5  = {f3_tf[29:0], 2'b0} + f3_tf + 32'd128;
  assign tcs = $signed(sra32(t5, 8));
  always_comb begin
    if (tcs < TEMP_MIN) begin
      tc4 = 15'(TEMP_MIN);
    end else if (tcs > TEMP_MAX) begin
      tc4 = 15'(TEMP_MAX);
    end else begin
      tc4 = tcs[14:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f4_q1 <= {{2{f3_tf[31]}}, f3_tf} - 34'd128000;
      f4_x  <= f3_tf - 32'd76800;
      f4_tc <= tc4;
      f4_p  <= f3_p;
      f4_h  <= f3_h;
    end
  end

  // stage 5
  logic signed [67:0] sq_full;
  logic signed [49:0] q5_full, qp2_full;
  logic [63:0] f5_sq, f5_q5, f5_qp2;
  logic [31:0] f5_hm5, f5_hf, f5_hg;
  logic [14:0] f5_tc;
  logic [19:0] f5_p;
  logic [15:0] f5_h;
  assign sq_full  = $signed(f4_q1) * $signed(f4_q1);
  assign q5_full  = $signed(f4_q1) * $signed(p5);
  assign qp2_full = $signed(f4_q1) * $signed(p2);
  always_ff @(posedge clk) begin
    if (adv) begin
      f5_sq  <= sq_full[63:0];
      f5_q5  <= {{14{q5_full[49]}}, q5_full};
      f5_qp2 <= {{14{qp2_full[49]}}, qp2_full};
      f5_hm5 <= h5s * f4_x;
      f5_hf  <= f4_x * h6s;
      f5_hg  <= f4_x * h3u;
      f5_tc  <= f4_tc;
      f5_p   <= f4_p;
      f5_h   <= f4_h;
    end
  end

  // stage 6
  logic [31:0] e6;
  logic [63:0] f6_a, f6_b, f6_q2p, f6_c;
  logic [31:0] f6_e, f6_f, f6_g;
  logic [14:0] f6_tc;
  logic [19:0] f6_p;
  assign e6 = {2'b0, f5_h, 14'b0} - {h4s[11:0], 20'b0} - f5_hm5;
  always_ff @(posedge clk) begin
    if (adv) begin
      f6_a   <= mul64s16(f5_sq, p6);
      f6_b   <= mul64s16(f5_sq, p3);
      f6_q2p <= {f5_q5[46:0], 17'b0} + {p4x[28:0], 35'b0};
      f6_c   <= {f5_qp2[51:0], 12'b0};
      f6_e   <= sra32(e6 + 32'd16384, 15);
      f6_f   <= sra32(f5_hf, 10);
      f6_g   <= sra32(f5_hg, 11) + 32'd32768;
      f6_tc  <= f5_tc;
      f6_p   <= f5_p;
    end
  end

  // stage 7
  logic [63:0] f7_q2, f7_d;
  logic [31:0] f7_e, f7_fg;
  logic [14:0] f7_tc;
  logic [19:0] f7_p;
  always_ff @(posedge clk) begin
    if (adv) begin
      f7_q2 <= f6_a + f6_q2p;
      f7_d  <= sra64(f6_b, 8) + f6_c + 64'h0000_8000_0000_0000;
      f7_e  <= f6_e;
      f7_fg <= f6_f * f6_g;
      f7_tc <= f6_tc;
      f7_p  <= f6_p;
    end
  end

  // stage 8
  logic [79:0] q1c_full;
  logic [63:0] pr0;
  logic [31:0] k8;
  logic [63:0] f8_q1c, f8_num0;
  logic [31:0] f8_e, f8_km;
  logic [14:0] f8_tc;
  assign q1c_full = {16'b0, f7_d} * {64'b0, p1};
  assign pr0      = 64'd1048576 - {44'b0, f7_p};
  assign k8       = sra32(f7_fg, 10) + 32'd2097152;
  always_ff @(posedge clk) begin
    if (adv) begin
      f8_q1c  <= q1c_full[63:0];
      f8_num0 <= {pr0[32:0], 31'b0} - f7_q2;
      f8_km   <= k8 * h2s;
      f8_e    <= f7_e;
      f8_tc   <= f7_tc;
    end
  end

  // stage 9
  logic [31:0] m9;
  logic [63:0] f9_div, f9_num;
  logic [31:0] f9_v;
  logic [14:0] f9_tc;
  assign m9 = sra32(f8_km + 32'd8192, 14);
  always_ff @(posedge clk) begin
    if (adv) begin
      f9_div <= sra64(f8_q1c, 33);
      f9_num <= f8_num0 * 64'd3125;
      f9_v   <= f8_e * m9;
      f9_tc  <= f8_tc;
    end
  end

  // stage 10: magnitudes for the divider
  logic [31:0] s10;
  logic [63:0] f10_un, f10_ud;
  logic        f10_neg, f10_zero;
  logic [31:0] f10_v, f10_ss;
  logic [14:0] f10_tc;
  assign s10 = sra32(f9_v, 15);
  always_ff @(posedge clk) begin
    if (adv) begin
      f10_un   <= f9_num[63] ? 64'd0 - f9_num : f9_num;
      f10_ud   <= f9_div[63] ? 64'd0 - f9_div : f9_div;
      f10_neg  <= f9_num[63] ^ f9_div[63];
      f10_zero <= (f9_div == 64'd0);
      f10_v    <= f9_v;
      f10_ss   <= s10 * s10;
      f10_tc   <= f9_tc;
    end
  end

  // stage 11
  logic [63:0] f11_un, f11_ud;
  logic        f11_neg, f11_zero;
  logic [31:0] f11_v, f11_wh;
  logic [14:0] f11_tc;
  always_ff @(posedge clk) begin
    if (adv) begin
      f11_un   <= f10_un;
      f11_ud   <= f10_ud;
      f11_neg  <= f10_neg;
      f11_zero <= f10_zero;
      f11_v    <= f10_v;
      f11_wh   <= sra32(f10_ss, 7) * h1u;
      f11_tc   <= f10_tc;
    end
  end

  // stage 12: humidity clamp
  logic [31:0] hv;
  logic [16:0] hum12;
  assign hv = f11_v - sra32(f11_wh, 4);
  always_comb begin
    if (hv[31]) begin
      hum12 = 17'd0;
    end else if (hv > 32'(HUM_MAX)) begin
      hum12 = 17'(HUM_MAX >> 12);
    end else begin
      hum12 = hv[28:12];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out.un      <= f11_un;
      out.ud      <= f11_ud;
      out.sd.neg  <= f11_neg;
      out.sd.zero <= f11_zero;
      out.sd.tc   <= f11_tc;
      out.sd.hum  <= hum12;
    end
  end

  assign out_vld = vld[11];

endmodule
`default_nettype wire

// ===== design/scc_div.sv =====
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// Side data travels with each item. Uses scc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scc_div import scc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_vld,
  input  wire fd_t  in,
  output logic      out_vld,
  output db_t       out
);

  logic [63:0] rem [1:DIV_BITS];
  logic [63:0] nq  [1:DIV_BITS];
  logic [63:0] dv  [1:DIV_BITS];
  side_t       sd  [1:DIV_BITS];
  logic        vld [1:DIV_BITS];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_st
    logic [63:0] prem, pnq, pdv;
    side_t       psd;
    logic        pv;
    logic [64:0] trial;
    logic        ge;
    if (i == 0) begin : g_first
      assign prem = 64'd0;
      assign pnq  = in.un;
      assign pdv  = in.ud;
      assign psd  = in.sd;
      assign pv   = in_vld;
    end else begin : g_rest
      assign prem = rem[i];
      assign pnq  = nq[i];
      assign pdv  = dv[i];
      assign psd  = sd[i];
      assign pv   = vld[i];
    end
    assign trial = {prem, pnq[63]};
    assign ge    = (trial >= {1'b0, pdv});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= pv;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? 64'(trial - {1'b0, pdv}) : trial[63:0];
        nq[i+1]  <= {pnq[62:0], ge};
        dv[i+1]  <= pdv;
        sd[i+1]  <= psd;
      end
    end
  end

  assign out_vld = vld[DIV_BITS];
  assign out.q   = nq[DIV_BITS];
  assign out.sd  = sd[DIV_BITS];

endmodule
`default_nettype wire

// ===== design/scc_back.sv =====
// Back pipeline: quotient sign, P7..P9 correction and pressure saturation.
// Six stages. Uses scc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scc_back import scc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_vld,
  input  wire db_t  in,
  input  wire cfg_t cfg,
  output logic      out_vld,
  output out_item_t out
);

  logic [5:0] vld;
  logic [15:0] p7, p8, p9;
  logic [63:0] p7x;

  assign p7 = cfg.p_hi[47:32];
  assign p8 = cfg.p_hi[63:48];
  assign p9 = cfg.p_last;
  assign p7x = sx16(p7);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], in_vld};
    end
  end

  // stage 1: signed quotient
  logic [63:0] b1_pr;
  side_t       b1_sd;
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_pr <= in.sd.neg ? 64'd0 - in.q : in.q;
      b1_sd <= in.sd;
    end
  end

  // stage 2: square of pr >> 13 by halves
  logic [63:0] hi2;
  logic [31:0] hl, hh;
  logic [63:0] b2_sqlo, b2_c2m, b2_pr;
  logic [31:0] b2_cross;
  side_t       b2_sd;
  assign hi2 = sra64(b1_pr, 13);
  assign hl  = hi2[31:0];
  assign hh  = hi2[63:32];
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_sqlo  <= {32'b0, hl} * {32'b0, hl};
      b2_cross <= hh * hl;
      b2_c2m   <= mul64s16(b1_pr, p8);
      b2_pr    <= b1_pr;
      b2_sd    <= b1_sd;
    end
  end

  // stage 3
  logic [63:0] b3_hisq, b3_c2, b3_pr;
  side_t       b3_sd;
  always_ff @(posedge clk) begin
    if (adv) begin
      b3_hisq <= b2_sqlo + {b2_cross[30:0], 1'b0, 32'b0};
      b3_c2   <= sra64(b2_c2m, 19);
      b3_pr   <= b2_pr;
      b3_sd   <= b2_sd;
    end
  end

  // stage 4
  logic [63:0] b4_c1m, b4_c2, b4_pr;
  side_t       b4_sd;
  always_ff @(posedge clk) begin
    if (adv) begin
      b4_c1m <= mul64s16(b3_hisq, p9);
      b4_c2  <= b3_c2;
      b4_pr  <= b3_pr;
      b4_sd  <= b3_sd;
    end
  end

  // stage 5
  logic [63:0] b5_prs;
  side_t       b5_sd;
  always_ff @(posedge clk) begin
    if (adv) begin
      b5_prs <= sra64(b4_pr + sra64(b4_c1m, 25) + b4_c2, 8) + {p7x[59:0], 4'b0};
      b5_sd  <= b4_sd;
    end
  end

  // stage 6: saturate
  logic [24:0] press6;
  always_comb begin
    if (b5_sd.zero || b5_prs[63]) begin
      press6 = 25'd0;
    end else if (b5_prs > 64'(PRESS_MAX)) begin
      press6 = 25'(PRESS_MAX);
    end else begin
      press6 = b5_prs[24:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out.tc    <= b5_sd.tc;
      out.press <= press6;
      out.pvld  <= !b5_sd.zero;
      out.hum   <= b5_sd.hum;
    end
  end

  assign out_vld = vld[5];

endmodule
`default_nettype wire

// ===== design/scc_skid.sv =====
// Two-entry output buffer between the pipeline and the result channel.
// Full is registered so the pipeline advance does not wait on tready. Uses scc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scc_skid import scc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t din,
  input  wire logic      pop,
  output logic           dout_vld,
  output out_item_t      dout,
  output skid_stat_t     stat
);

  out_item_t   buf_q [0:1];
  logic        wptr, rptr;
  logic [1:0]  cnt;
  logic        do_pop;

  assign do_pop = pop && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wptr] <= din;
    end
  end

  assign dout_vld   = (cnt != 2'd0);
  assign dout       = buf_q[rptr];
  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);

endmodule
`default_nettype wire

// ===== design/sensor_calibration_compensation.sv =====
// Environmental sensor integer compensation, top level.
// Instantiates scc_front, scc_div, scc_back and scc_skid; uses scc_pkg.
//
// One raw sample set in, one compensated result out. The datapath is a fixed
// pipeline of 82 register stages (12 front, 64 divider, 6 back) plus a
// two-entry output buffer, and one item is taken every cycle while the output
// buffer is not full. The 64-stage pressure divider is the longest section.
// Calibration writes take effect for items accepted afterward; write them
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_calibration_compensation_macros.svh"
module sensor_calibration_compensation import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // raw_temperature, raw_pressure, raw_humidity
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // temperature_centideg, pressure_q17_8,
                                      // humidity_q7_10, zero pad
  output logic             m_tuser,   // pressure_valid
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t       cfg;
  logic       adv;
  logic       fr_vld, dv_vld, bk_vld;
  fd_t        fr_out;
  db_t        dv_out;
  out_item_t  bk_out, sk_out;
  skid_stat_t skid_st;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_CAL:   cfg.t_cal  <= cfg_data[47:0];
        CFG_PRESS_LOW:  cfg.p_lo   <= cfg_data;
        CFG_PRESS_HIGH: cfg.p_hi   <= cfg_data;
        CFG_PRESS_LAST: cfg.p_last <= cfg_data[15:0];
        CFG_HUM_CAL:    cfg.h_cal  <= cfg_data;
        CFG_FINE_OFF:   cfg.t_off  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign adv      = !skid_st.full;
  assign s_tready = adv && !rst;

  scc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (s_tvalid),
    .raw_t   (s_tdata[19:0]),
    .raw_p   (s_tdata[39:20]),
    .raw_h   (s_tdata[55:40]),
    .cfg     (cfg),
    .out_vld (fr_vld),
    .out     (fr_out)
  );

  scc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (fr_vld),
    .in      (fr_out),
    .out_vld (dv_vld),
    .out     (dv_out)
  );

  scc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (dv_vld),
    .in      (dv_out),
    .cfg     (cfg),
    .out_vld (bk_vld),
    .out     (bk_out)
  );

  scc_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (adv && bk_vld),
    .din      (bk_out),
    .pop      (m_tready),
    .dout_vld (m_tvalid),
    .dout     (sk_out),
    .stat     (skid_st)
  );

  assign m_tdata = {7'b0, sk_out.hum, sk_out.press, sk_out.tc};
  assign m_tuser = sk_out.pvld;

  `SCC_ASSERT_IMP(a_full_has_item, clk, rst, skid_st.full, m_tvalid && !skid_st.empty)
  `SCC_ASSERT_IMP(a_pinv_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[39:15] == 25'd0)
  `SCC_ASSERT_IMP(a_hum_range, clk, rst, m_tvalid, m_tdata[56:40] <= 17'd102400)
  `SCC_ASSERT_NXT(a_full_blocks, clk, rst, skid_st.full && !m_tready, !s_tready)

endmodule
`default_nettype wire

// ===== verif/sensor_calibration_compensation_tb.sv =====
// Testbench for sensor_calibration_compensation: drives raw sample sets and
// calibration writes, and predicts and checks each compensated result.
// Depends on scc_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module sensor_calibration_compensation_tb;
  import scc_pkg::*;

  typedef struct packed {
    logic [14:0] temp;
    logic [24:0] press;
    logic        pvld;
    logic [16:0] hum;
  } comp_t;

  class comp_scoreboard;
    cfg_t  cal;
    comp_t pending[$];
    int    errors;

    function new();
      cal = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] d);
      case (idx)
        CFG_TEMP_CAL:   cal.t_cal = d[47:0];
        CFG_PRESS_LOW:  cal.p_lo = d;
        CFG_PRESS_HIGH: cal.p_hi = d;
        CFG_PRESS_LAST: cal.p_last = d[15:0];
        CFG_HUM_CAL:    cal.h_cal = d;
        CFG_FINE_OFF:   cal.t_off = d[19:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] asr32(logic [31:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    function logic [63:0] asr64(logic [63:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    function logic [63:0] ext16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function comp_t compensate(logic [55:0] raw);
      comp_t r;
      logic [31:0] adc_t, adc_h, t1, t2, t3, off, a, b, v1, v2, tfine, tcv;
      logic [31:0] h1, h2, h3, h4, h5, h6, x, e, f, g, k, m, v, s, w;
      logic [63:0] adc_p, q1, q2, pr, num, un, ud, quo, hi, c1, c2;
      int tci, hv;
      adc_t = {12'b0, raw[19:0]};
      adc_p = {44'b0, raw[39:20]};
      adc_h = {16'b0, raw[55:40]};
      t1 = {16'b0, cal.t_cal[15:0]};
      t2 = {{16{cal.t_cal[31]}}, cal.t_cal[31:16]};
      t3 = {{16{cal.t_cal[47]}}, cal.t_cal[47:32]};
      off = {{12{cal.t_off[19]}}, cal.t_off};
      a = (adc_t >> 3) - (t1 << 1);
      v1 = asr32(a * t2, 11);
      b = (adc_t >> 4) - t1;
      v2 = asr32(asr32(b * b, 12) * t3, 14);
      tfine = v1 + v2 + off;
      tcv = asr32(tfine * 32'd5 + 32'd128, 8);
      tci = $signed(tcv);
      if (tci < -4000) tci = -4000;
      if (tci > 8500) tci = 8500;
      r.temp = tci[14:0];

      q1 = {{32{tfine[31]}}, tfine} - 64'd128000;
      q2 = q1 * q1 * ext16(cal.p_hi[31:16]);
      q2 = q2 + ((q1 * ext16(cal.p_hi[15:0])) << 17);
      q2 = q2 + (ext16(cal.p_lo[63:48]) << 35);
      q1 = asr64(q1 * q1 * ext16(cal.p_lo[47:32]), 8)
         + ((q1 * ext16(cal.p_lo[31:16])) << 12);
      q1 = asr64(((64'd1 << 47) + q1) * {48'b0, cal.p_lo[15:0]}, 33);
      if (q1 == 64'd0) begin
        r.press = '0;
        r.pvld = 1'b0;
      end else begin
        pr = 64'd1048576 - adc_p;
        num = ((pr << 31) - q2) * 64'd3125;
        un = num[63] ? -num : num;
        ud = q1[63] ? -q1 : q1;
        quo = un / ud;
        pr = (num[63] != q1[63]) ? -quo : quo;
        hi = asr64(pr, 13);
        c1 = asr64(ext16(cal.p_last) * hi * hi, 25);
        c2 = asr64(ext16(cal.p_hi[63:48]) * pr, 19);
        pr = asr64(pr + c1 + c2, 8) + (ext16(cal.p_hi[47:32]) << 4);
        if (pr[63]) pr = 64'd0;
        else if (pr > 64'd33554431) pr = 64'd33554431;
        r.press = pr[24:0];
        r.pvld = 1'b1;
      end

      h1 = {24'b0, cal.h_cal[7:0]};
      h2 = {{16{cal.h_cal[23]}}, cal.h_cal[23:8]};
      h3 = {24'b0, cal.h_cal[31:24]};
      h4 = {{20{cal.h_cal[43]}}, cal.h_cal[43:32]};
      h5 = {{20{cal.h_cal[55]}}, cal.h_cal[55:44]};
      h6 = {{24{cal.h_cal[63]}}, cal.h_cal[63:56]};
      x = tfine - 32'd76800;
      e = (adc_h << 14) - (h4 << 20) - h5 * x;
      e = asr32(e + 32'd16384, 15);
      f = asr32(x * h6, 10);
      g = asr32(x * h3, 11) + 32'd32768;
      k = asr32(f * g, 10) + 32'd2097152;
      m = asr32(k * h2 + 32'd8192, 14);
      v = e * m;
      s = asr32(v, 15);
      w = asr32(s * s, 7);
      v = v - asr32(w * h1, 4);
      hv = $signed(v);
      if (hv < 0) hv = 0;
      if (hv > 419430400) hv = 419430400;
      r.hum = hv[28:12];
      return r;
    endfunction

    function void note(logic [55:0] raw);
      pending.push_back(compensate(raw));
    endfunction

    function void check(comp_t got);
      comp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: temp %0d/%0d press %0d/%0d valid %0b/%0b hum %0d/%0d",
                   $signed(exp.temp), $signed(got.temp), exp.press, got.press,
                   exp.pvld, got.pvld, exp.hum, got.hum);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  comp_scoreboard sb;
  int gap_max, stall_max, stall_left, stall_draw, quiet;

  sensor_calibration_compensation uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note(s_tdata);
  end

  // stall draw: m_tready drops for the drawn count, then rises again
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check({m_tdata[14:0], m_tdata[39:15], m_tuser, m_tdata[56:40]});
      stall_draw = $urandom_range(0, stall_max);
      stall_left <= stall_draw;
      m_tready <= (stall_draw == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == 5000) begin
        $display("sensor_calibration_compensation verification failed");
        $finish;
      end
    end
  end

  task automatic send(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rh, rp, rt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                          logic [15:0] p9, logic [63:0] hc, logic [19:0] off);
    drain();
    cfg_write(CFG_TEMP_CAL, tc);
    cfg_write(CFG_PRESS_LOW, pl);
    cfg_write(CFG_PRESS_HIGH, ph);
    cfg_write(CFG_PRESS_LAST, {48'b0, p9});
    cfg_write(CFG_HUM_CAL, hc);
    cfg_write(CFG_FINE_OFF, {44'b0, off});
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      end
      send(20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 1048575)),
           16'($urandom_range(0, 65535)));
    end
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  localparam logic [63:0] T_TYP  = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] PL_TYP = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] PH_TYP = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
  localparam logic [63:0] H_TYP  = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TEMP_CAL;
    cfg_data = '0;
    gap_max = 0;
    stall_max = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: zero divisor path
    send(20'd0, 20'd0, 16'd0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send(20'd519888, 20'd415148, 16'd30000);

    load_cal(T_TYP, PL_TYP, PH_TYP, 16'd6000, H_TYP, 20'd0);
    send(20'd519888, 20'd415148, 16'd30000);
    send(20'd0, 20'd0, 16'd0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send(20'd0, 20'hFFFFF, 16'hFFFF);
    send(20'hFFFFF, 20'd0, 16'd0);
    send(20'd400000, 20'd300000, 16'd40000);
    send(20'd600000, 20'd200000, 16'd10000);

    load_cal(T_TYP, PL_TYP, PH_TYP, 16'h8000, H_TYP, 20'h80000);
    send(20'd519888, 20'd415148, 16'd30000);
    send(20'hFFFFF, 20'd0, 16'hFFFF);
    load_cal(T_TYP, PL_TYP, PH_TYP, 16'h7FFF, H_TYP, 20'h7FFFF);
    send(20'd519888, 20'd415148, 16'd30000);
    send(20'd0, 20'hFFFFF, 16'd0);
    load_cal('1, '1, '1, 16'hFFFF, '1, 20'hFFFFF);
    send(20'd0, 20'd0, 16'd0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    load_cal({16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF},
             {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000,
             {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h8000, 8'hFF}, 20'h80000);
    send(20'd519888, 20'd415148, 16'd30000);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);

    load_cal(T_TYP, PL_TYP, PH_TYP, 16'd6000, H_TYP, 20'd0);
    random_items(120);
    load_cal(T_TYP ^ {28'b0, $urandom_range(0, 255), 4'b0},
             PL_TYP ^ {32'b0, $urandom_range(0, 255)},
             PH_TYP ^ {16'b0, $urandom_range(0, 255), 16'b0},
             16'($urandom_range(0, 16'hFFFF)),
             H_TYP ^ {$urandom_range(0, 15), 32'b0},
             20'($urandom_range(0, 20'hFFFFF)));
    random_items(100);
    load_cal(rnd64(), rnd64(), rnd64(), 16'($urandom), rnd64(), 20'($urandom));
    random_items(60);
    load_cal(rnd64(), rnd64(), rnd64(), 16'($urandom), rnd64(), 20'($urandom));
    random_items(60);
    load_cal(T_TYP, PL_TYP, PH_TYP, 16'd6000, H_TYP, 20'($urandom));
    random_items(60);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sensor_calibration_compensation verification clean");
    end else begin
      $display("sensor_calibration_compensation verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/scc_pkg.sv
design/scc_front.sv
design/scc_div.sv
design/scc_back.sv
design/scc_skid.sv
design/sensor_calibration_compensation.sv
verif/sensor_calibration_compensation_tb.sv
